/* rtl/core/rlrs_pkg.sv */
// Shared widths, types, register indexes and reset values for the range smoother.
package rlrs_pkg;

    localparam int COORD_W    = 24;
    localparam int TIME_W     = 48;
    localparam int DIST_W     = 23;
    localparam int INTERVAL_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 23;
    localparam int MAG_W      = 25;
    localparam int PROD_W     = 2 * MAG_W;
    localparam int RAD_W      = 50;
    localparam int ROOT_W     = 25;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [TIME_W-1:0]         time_t;
    typedef logic [DIST_W-1:0]         dist_t;
    typedef logic [INTERVAL_W-1:0]     interval_t;
    typedef logic [CFG_IDX_W-1:0]      cfg_index_t;
    typedef logic [CFG_DATA_W-1:0]     cfg_data_t;
    typedef logic [MAG_W-1:0]          mag_t;
    typedef logic [PROD_W-1:0]         prod_t;
    typedef logic [RAD_W-1:0]          rad_t;
    typedef logic [ROOT_W-1:0]         root_t;

    localparam cfg_index_t CFG_TRACING  = 2'd0;
    localparam cfg_index_t CFG_MAX      = 2'd1;
    localparam cfg_index_t CFG_MIN      = 2'd2;
    localparam cfg_index_t CFG_INTERVAL = 2'd3;

    localparam logic REQ_FRAME = 1'b0;
    localparam logic REQ_RESET = 1'b1;

    localparam dist_t     MAX_RANGE_RST = 23'd2015744;
    localparam dist_t     MIN_RANGE_RST = 23'd2048;
    localparam interval_t INTERVAL_RST  = 16'd66;

endpackage

/* rtl/core/rlrs_blend_rom.sv */
// Blend factor table 1-exp(-dt/tau), built at elaboration, registered read.
module rlrs_blend_rom #(
    parameter int SMOOTHING_MS      = 120,
    parameter int BLEND_TABLE_DEPTH = 1024,
    parameter int BLEND_FRAC_BITS   = 16
) (
    input  logic                                 clk,
    input  logic [$clog2(BLEND_TABLE_DEPTH)-1:0] addr,
    output logic [BLEND_FRAC_BITS:0]             data
);

    typedef logic [BLEND_FRAC_BITS:0] entry_t;
    typedef entry_t blend_table_t [BLEND_TABLE_DEPTH];

    localparam longint unsigned Q30_ONE = 64'd1 << 30;
    localparam int              SH      = 30 - BLEND_FRAC_BITS;
    // 1/tau in Q2.30, the step of the series
    localparam longint unsigned X_Q30   = (Q30_ONE + SMOOTHING_MS / 2) / SMOOTHING_MS;

    // shift-and-subtract quotient, used only while the table is built
    function automatic longint unsigned udiv(input longint unsigned num,
                                             input longint unsigned den);
        longint unsigned q;
        longint unsigned rem;
        q   = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[62:0], num[b]};
            q   = {q[62:0], 1'b0};
            if (rem >= den)
            begin
                rem = rem - den;
                q   = q | 64'd1;
            end
        end
        return q;
    endfunction

    function automatic blend_table_t build_table();
        longint unsigned term;
        longint unsigned den;
        longint unsigned r;
        longint unsigned e;
        longint          sum;
        blend_table_t    t;
        term = Q30_ONE;
        sum  = longint'(Q30_ONE);
        // series for exp(-1/tau)
        for (int k = 1; k <= 24; k++)
        begin
            den  = longint'(k) << 30;
            term = udiv(term * X_Q30 + (den >> 1), den);
            if ((k & 1) == 1)
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        if (sum < 0)
            sum = 0;
        if (sum > longint'(Q30_ONE))
            sum = longint'(Q30_ONE);
        r = longint'(sum);
        e = Q30_ONE;
        for (int i = 0; i < BLEND_TABLE_DEPTH; i++)
        begin
            t[i] = entry_t'(((Q30_ONE - e) + ((64'd1 << SH) >> 1)) >> SH);
            e    = (e * r + (Q30_ONE >> 1)) >> 30;
        end
        return t;
    endfunction

    localparam blend_table_t BLEND_TABLE = build_table();

    always_ff @(posedge clk)
    begin
        data <= BLEND_TABLE[addr];
    end

endmodule

/* rtl/core/rlrs_isqrt.sv */
// Iterative integer square root, two radicand bits per cycle.
module rlrs_isqrt (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  rlrs_pkg::rad_t  radicand,
    output logic          done,
    output rlrs_pkg::root_t root
);
    import rlrs_pkg::*;

    localparam rad_t FIRST_BIT = RAD_W'(1) << (RAD_W - 2);

    rad_t v_reg, v_next;
    rad_t res_reg, res_next;
    rad_t bit_reg, bit_next;
    logic busy_reg, busy_next;
    logic done_reg, done_next;
    rad_t trial;

    always_comb
    begin
        v_next    = v_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = res_reg + bit_reg;
        if (start)
        begin
            v_next    = radicand;
            res_next  = '0;
            bit_next  = FIRST_BIT;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (v_reg >= trial)
            begin
                v_next   = v_reg - trial;
                res_next = (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            // last digit pair processed
            if (bit_reg[0])
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg    <= '0;
            res_reg  <= '0;
            bit_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v_reg    <= v_next;
            res_reg  <= res_next;
            bit_reg  <= bit_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done = done_reg;
    assign root = res_reg[ROOT_W-1:0];

endmodule

/* rtl/core/rate_limited_range_smoother.sv */
// Rate-limited range smoother: sequencer, shared multiplier and smoother state.
//
// Input channel (in_valid/in_ready) takes one word per request: a frame query
// with time, eye point, hit point and hit flag, or a sample reset. Output
// channel (out_valid/out_ready) returns exactly one word per request:
// distance_valid and aim_distance.
// in_ready is high only while the sequencer is idle. A word that needs no new
// measurement (reset, tracing off, interval not elapsed) goes straight to emit.
// A measurement squares the three axis offsets in the shared 25x25 multiplier,
// starts the square-root unit and waits on it (25 digit pairs, one a cycle,
// then its done flag), then makes the window check, and for a blend a table
// read and one blend multiply.
// The output register holds a finished word while the next request is taken;
// a stalled receiver holds the sequencer only when a second result is ready.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once and
// are expected only while the block is idle.
// Reset clears the held sample, both timestamps and the output register and
// loads the register defaults (tracing off).
module rate_limited_range_smoother #(
    parameter int SMOOTHING_MS      = 120,
    parameter int BLEND_TABLE_DEPTH = 1024,
    parameter int BLEND_FRAC_BITS   = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  rlrs_pkg::cfg_index_t cfg_index,
    input  rlrs_pkg::cfg_data_t  cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 req_type,
    input  rlrs_pkg::time_t      now_ms,
    input  logic                 hit_found,
    input  rlrs_pkg::coord_t     eye_x,
    input  rlrs_pkg::coord_t     eye_y,
    input  rlrs_pkg::coord_t     eye_z,
    input  rlrs_pkg::coord_t     hit_x,
    input  rlrs_pkg::coord_t     hit_y,
    input  rlrs_pkg::coord_t     hit_z,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 distance_valid,
    output rlrs_pkg::dist_t      aim_distance
);
    import rlrs_pkg::*;

    localparam int    ADDR_W   = $clog2(BLEND_TABLE_DEPTH);
    localparam time_t LAST_IDX = TIME_W'(BLEND_TABLE_DEPTH - 1);
    localparam prod_t HALF     = PROD_W'(1) << (BLEND_FRAC_BITS - 1);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_SQUARE    = 4'd1;
    localparam logic [3:0] S_SQRT_GO   = 4'd2;
    localparam logic [3:0] S_SQRT_WAIT = 4'd3;
    localparam logic [3:0] S_CHECK     = 4'd4;
    localparam logic [3:0] S_ROM       = 4'd5;
    localparam logic [3:0] S_MUL       = 4'd6;
    localparam logic [3:0] S_ADD       = 4'd7;
    localparam logic [3:0] S_EMIT      = 4'd8;

    function automatic mag_t abs_diff(input coord_t a, input coord_t b);
        logic signed [MAG_W-1:0] d;
        d = MAG_W'(a) - MAG_W'(b);
        return d[MAG_W-1] ? mag_t'(-d) : mag_t'(d);
    endfunction

    logic [3:0]        state_reg, state_next;
    logic [1:0]        cnt_reg, cnt_next;
    mag_t              ax_reg, ax_next;
    mag_t              ay_reg, ay_next;
    mag_t              az_reg, az_next;
    rad_t              acc_reg, acc_next;
    prod_t             prod_reg, prod_next;
    time_t             now_reg, now_next;
    logic              hit_reg, hit_next;
    root_t             d_reg, d_next;
    dist_t             diff_reg, diff_next;
    logic              up_reg, up_next;
    logic [ADDR_W-1:0] rom_addr_reg, rom_addr_next;
    logic              res_valid_reg, res_valid_next;
    dist_t             res_dist_reg, res_dist_next;
    logic              out_valid_reg, out_valid_next;
    logic              dist_valid_reg, dist_valid_next;
    dist_t             aim_reg, aim_next;
    logic              tracing_reg, tracing_next;
    dist_t             max_reg, max_next;
    dist_t             min_reg, min_next;
    interval_t         interval_reg, interval_next;
    dist_t             smooth_reg, smooth_next;
    logic              held_reg, held_next;
    time_t             lmt_reg, lmt_next;
    time_t             lut_reg, lut_next;

    mag_t                   mul_a;
    mag_t                   mul_b;
    prod_t                  product;
    mag_t                   comp;
    time_t                  elapsed;
    time_t                  dt;
    prod_t                  rnd;
    dist_t                  delta;
    dist_t                  blended;
    logic                   sqrt_start;
    logic                   sqrt_done;
    root_t                  root;
    logic [BLEND_FRAC_BITS:0] rom_data;

    rlrs_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (acc_reg),
        .done     (sqrt_done),
        .root     (root)
    );

    rlrs_blend_rom #(
        .SMOOTHING_MS      (SMOOTHING_MS),
        .BLEND_TABLE_DEPTH (BLEND_TABLE_DEPTH),
        .BLEND_FRAC_BITS   (BLEND_FRAC_BITS)
    ) u_blend_rom (
        .clk  (clk),
        .addr (rom_addr_reg),
        .data (rom_data)
    );

    // shared multiplier: squares first, then the blend product
    always_comb
    begin
        case (cnt_reg)
            2'd0:    comp = ax_reg;
            2'd1:    comp = ay_reg;
            default: comp = az_reg;
        endcase
        if (state_reg == S_MUL)
        begin
            mul_a = MAG_W'(diff_reg);
            mul_b = MAG_W'(rom_data);
        end
        else
        begin
            mul_a = comp;
            mul_b = comp;
        end
    end

    assign product = mul_a * mul_b;
    assign elapsed = now_ms - lmt_reg;
    assign dt      = now_reg - lut_reg;
    assign rnd     = prod_reg + HALF;
    assign delta   = rnd[BLEND_FRAC_BITS +: DIST_W];
    assign blended = up_reg ? smooth_reg + delta : smooth_reg - delta;

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        ax_next         = ax_reg;
        ay_next         = ay_reg;
        az_next         = az_reg;
        acc_next        = acc_reg;
        prod_next       = prod_reg;
        now_next        = now_reg;
        hit_next        = hit_reg;
        d_next          = d_reg;
        diff_next       = diff_reg;
        up_next         = up_reg;
        rom_addr_next   = rom_addr_reg;
        res_valid_next  = res_valid_reg;
        res_dist_next   = res_dist_reg;
        out_valid_next  = out_valid_reg;
        dist_valid_next = dist_valid_reg;
        aim_next        = aim_reg;
        tracing_next    = tracing_reg;
        max_next        = max_reg;
        min_next        = min_reg;
        interval_next   = interval_reg;
        smooth_next     = smooth_reg;
        held_next       = held_reg;
        lmt_next        = lmt_reg;
        lut_next        = lut_reg;
        sqrt_start      = 1'b0;

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_TRACING:  tracing_next  = cfg_data[0];
                CFG_MAX:      max_next      = cfg_data;
                CFG_MIN:      min_next      = cfg_data;
                CFG_INTERVAL: interval_next = cfg_data[INTERVAL_W-1:0];
                default:      ;
            endcase
        end

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    now_next = now_ms;
                    hit_next = hit_found;
                    ax_next  = abs_diff(hit_x, eye_x);
                    ay_next  = abs_diff(hit_y, eye_y);
                    az_next  = abs_diff(hit_z, eye_z);
                    acc_next = '0;
                    cnt_next = 2'd0;
                    if (req_type == REQ_RESET)
                    begin
                        held_next      = 1'b0;
                        smooth_next    = '0;
                        res_valid_next = 1'b0;
                        res_dist_next  = '0;
                        state_next     = S_EMIT;
                    end
                    else if (!tracing_reg)
                    begin
                        res_valid_next = 1'b0;
                        res_dist_next  = '0;
                        state_next     = S_EMIT;
                    end
                    else if (!held_reg || elapsed >= TIME_W'(interval_reg))
                    begin
                        state_next = S_SQUARE;
                    end
                    else
                    begin
                        // hold the current sample, only advance the update time
                        lut_next       = now_ms;
                        res_valid_next = 1'b1;
                        res_dist_next  = smooth_reg;
                        state_next     = S_EMIT;
                    end
                end
            end
            S_SQUARE:
            begin
                if (cnt_reg != 2'd3)
                    prod_next = product;
                if (cnt_reg != 2'd0)
                    acc_next = acc_reg + prod_reg;
                if (cnt_reg == 2'd3)
                begin
                    cnt_next   = 2'd0;
                    state_next = S_SQRT_GO;
                end
                else
                begin
                    cnt_next = cnt_reg + 2'd1;
                end
            end
            S_SQRT_GO:
            begin
                sqrt_start = 1'b1;
                state_next = S_SQRT_WAIT;
            end
            S_SQRT_WAIT:
            begin
                if (sqrt_done)
                    state_next = S_CHECK;
            end
            S_CHECK:
            begin
                d_next   = root;
                lmt_next = now_reg;
                if (!hit_reg || root <= ROOT_W'(min_reg) || root >= ROOT_W'(max_reg))
                begin
                    // drop the sample
                    held_next      = 1'b0;
                    res_valid_next = 1'b0;
                    res_dist_next  = '0;
                    state_next     = S_EMIT;
                end
                else if (!held_reg)
                begin
                    smooth_next    = root[DIST_W-1:0];
                    held_next      = 1'b1;
                    lut_next       = now_reg;
                    res_valid_next = 1'b1;
                    res_dist_next  = root[DIST_W-1:0];
                    state_next     = S_EMIT;
                end
                else
                begin
                    if (dt >= LAST_IDX)
                        rom_addr_next = LAST_IDX[ADDR_W-1:0];
                    else
                        rom_addr_next = dt[ADDR_W-1:0];
                    state_next = S_ROM;
                end
            end
            S_ROM:
            begin
                up_next = d_reg[DIST_W-1:0] >= smooth_reg;
                if (d_reg[DIST_W-1:0] >= smooth_reg)
                    diff_next = d_reg[DIST_W-1:0] - smooth_reg;
                else
                    diff_next = smooth_reg - d_reg[DIST_W-1:0];
                state_next = S_MUL;
            end
            S_MUL:
            begin
                prod_next  = product;
                state_next = S_ADD;
            end
            S_ADD:
            begin
                smooth_next    = blended;
                lut_next       = now_reg;
                res_valid_next = 1'b1;
                res_dist_next  = blended;
                state_next     = S_EMIT;
            end
            S_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    dist_valid_next = res_valid_reg;
                    aim_next        = res_dist_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            ax_reg         <= '0;
            ay_reg         <= '0;
            az_reg         <= '0;
            acc_reg        <= '0;
            prod_reg       <= '0;
            now_reg        <= '0;
            hit_reg        <= 1'b0;
            d_reg          <= '0;
            diff_reg       <= '0;
            up_reg         <= 1'b0;
            rom_addr_reg   <= '0;
            res_valid_reg  <= 1'b0;
            res_dist_reg   <= '0;
            out_valid_reg  <= 1'b0;
            dist_valid_reg <= 1'b0;
            aim_reg        <= '0;
            tracing_reg    <= 1'b0;
            max_reg        <= MAX_RANGE_RST;
            min_reg        <= MIN_RANGE_RST;
            interval_reg   <= INTERVAL_RST;
            smooth_reg     <= '0;
            held_reg       <= 1'b0;
            lmt_reg        <= '0;
            lut_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            ax_reg         <= ax_next;
            ay_reg         <= ay_next;
            az_reg         <= az_next;
            acc_reg        <= acc_next;
            prod_reg       <= prod_next;
            now_reg        <= now_next;
            hit_reg        <= hit_next;
            d_reg          <= d_next;
            diff_reg       <= diff_next;
            up_reg         <= up_next;
            rom_addr_reg   <= rom_addr_next;
            res_valid_reg  <= res_valid_next;
            res_dist_reg   <= res_dist_next;
            out_valid_reg  <= out_valid_next;
            dist_valid_reg <= dist_valid_next;
            aim_reg        <= aim_next;
            tracing_reg    <= tracing_next;
            max_reg        <= max_next;
            min_reg        <= min_next;
            interval_reg   <= interval_next;
            smooth_reg     <= smooth_next;
            held_reg       <= held_next;
            lmt_reg        <= lmt_next;
            lut_reg        <= lut_next;
        end
    end

    assign in_ready       = (state_reg == S_IDLE);
    assign out_valid      = out_valid_reg;
    assign distance_valid = dist_valid_reg;
    assign aim_distance   = aim_reg;

endmodule

/* bench/testbench.sv */
// Self-checking bench for the rate-limited range smoother: random traffic, predictor, scoreboard.
`timescale 1ns / 1ps

module testbench;
    import rlrs_pkg::*;

    localparam int SMOOTH_MS   = 120;
    localparam int TAB_DEPTH   = 1024;
    localparam int FRAC_BITS   = 16;
    localparam int LIMIT_CYCLES = 1000000;
    localparam int DRAIN_CYCLES = 64;
    localparam int MAX_PRINTS  = 200;

    localparam longint unsigned Q30 = 64'h4000_0000;
    localparam longint COORD_MAX = 8388607;
    localparam longint COORD_MIN = -8388608;

    typedef enum logic [1:0] {STEP_WORD, STEP_CFG, STEP_DRAIN} step_kind_e;

    typedef struct packed {
        step_kind_e kind;
        logic       req;
        time_t      now;
        logic       hit;
        coord_t     ex;
        coord_t     ey;
        coord_t     ez;
        coord_t     hx;
        coord_t     hy;
        coord_t     hz;
        cfg_index_t idx;
        cfg_data_t  data;
    } step_t;

    typedef struct packed {
        logic  present;
        dist_t dist_q8;
    } aim_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_we = 1'b0;
    cfg_index_t cfg_index = CFG_TRACING;
    cfg_data_t  cfg_data = '0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic       req_type = REQ_FRAME;
    time_t      now_ms = '0;
    logic       hit_found = 1'b0;
    coord_t     eye_x = '0;
    coord_t     eye_y = '0;
    coord_t     eye_z = '0;
    coord_t     hit_x = '0;
    coord_t     hit_y = '0;
    coord_t     hit_z = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic       distance_valid;
    dist_t      aim_distance;

    // predictor copy of the registers and smoother state
    logic       trc_en = 1'b0;
    dist_t      rng_max = MAX_RANGE_RST;
    dist_t      rng_min = MIN_RANGE_RST;
    interval_t  interval = INTERVAL_RST;
    logic [23:0] sm_range = '0;
    logic       held = 1'b0;
    time_t      last_meas = '0;
    time_t      last_upd = '0;

    longint unsigned blend_gain [TAB_DEPTH];

    step_t plan_q [$];
    aim_t  expected_aims [$];
    time_t sim_ms = '0;
    step_t cur_word;

    int send_gap = 0;
    int send_left = 0;
    bit send_quiet = 1'b0;
    int recv_gap = 0;
    int recv_left = 0;
    bit recv_quiet = 1'b0;
    int long_hold = 0;

    int err_count = 0;
    int words_sent = 0;
    int results_seen = 0;
    int valid_seen = 0;
    int cfg_writes = 0;
    int cycles = 0;

    rate_limited_range_smoother dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .req_type       (req_type),
        .now_ms         (now_ms),
        .hit_found      (hit_found),
        .eye_x          (eye_x),
        .eye_y          (eye_y),
        .eye_z          (eye_z),
        .hit_x          (hit_x),
        .hit_y          (hit_y),
        .hit_z          (hit_z),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .distance_valid (distance_valid),
        .aim_distance   (aim_distance)
    );

    always #5 clk = ~clk;

    task automatic report_mismatch(input string what);
        err_count++;
        if (err_count <= MAX_PRINTS)
            $display("[%0t] mismatch: %s", $time, what);
    endtask

    // 1 - exp(-dt/tau) in Q0.16, one entry per millisecond of gap
    function automatic void build_gain_table();
        longint unsigned x;
        longint unsigned term;
        longint unsigned den;
        longint unsigned decay;
        longint unsigned e;
        longint          sum;
        int              k;
        int              i;
        x = (Q30 + SMOOTH_MS / 2) / SMOOTH_MS;
        term = Q30;
        sum = longint'(Q30);
        for (k = 1; k <= 24; k++)
        begin
            den = longint'(k) << 30;
            term = (term * x + den / 2) / den;
            if (k % 2 == 1)
                sum -= longint'(term);
            else
                sum += longint'(term);
        end
        if (sum < 0)
            sum = 0;
        if (sum > longint'(Q30))
            sum = longint'(Q30);
        decay = longint'(sum);
        e = Q30;
        for (i = 0; i < TAB_DEPTH; i++)
        begin
            blend_gain[i] = ((Q30 - e) + ((64'd1 << (30 - FRAC_BITS)) >> 1)) >> (30 - FRAC_BITS);
            e = (e * decay + (Q30 >> 1)) >> 30;
        end
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (v >= root + bitv)
            begin
                v -= root + bitv;
                root = (root >> 1) + bitv;
            end
            else
                root >>= 1;
            bitv >>= 2;
        end
        return root;
    endfunction

    function automatic longint unsigned axis_sq(input coord_t a, input coord_t b);
        longint diff;
        diff = longint'(b) - longint'(a);
        if (diff < 0)
            diff = -diff;
        return longint'(diff) * longint'(diff);
    endfunction

    // advance the smoother by one accepted word and queue the result it owes
    function automatic void predict_aim(input step_t w);
        aim_t            res;
        time_t           since;
        longint unsigned d;
        longint unsigned gap;
        longint unsigned gain;
        longint unsigned cur;
        longint unsigned delta;
        bit              dropped;
        res = '0;
        if (w.req == REQ_RESET)
        begin
            held = 1'b0;
            sm_range = '0;
        end
        else if (trc_en)
        begin
            dropped = 1'b0;
            since = w.now - last_meas;
            if (!held || since >= interval)
            begin
                d = int_sqrt(axis_sq(w.ex, w.hx) + axis_sq(w.ey, w.hy) + axis_sq(w.ez, w.hz));
                last_meas = w.now;
                if (!w.hit || d <= rng_min || d >= rng_max)
                begin
                    held = 1'b0;
                    dropped = 1'b1;
                end
                else if (!held)
                begin
                    sm_range = d[23:0];
                    held = 1'b1;
                end
                else
                begin
                    since = w.now - last_upd;
                    gap = (since < TAB_DEPTH - 1) ? since : TAB_DEPTH - 1;
                    gain = blend_gain[gap];
                    cur = sm_range;
                    if (d >= cur)
                    begin
                        delta = ((d - cur) * gain + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
                        cur += delta;
                    end
                    else
                    begin
                        delta = ((cur - d) * gain + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
                        cur -= delta;
                    end
                    sm_range = cur[23:0];
                end
            end
            if (!dropped)
            begin
                last_upd = w.now;
                if (held)
                begin
                    res.present = 1'b1;
                    res.dist_q8 = sm_range[DIST_W-1:0];
                end
            end
        end
        expected_aims.push_back(res);
    endfunction

    // random per-item wait, with runs of back-to-back items mixed in
    function automatic int draw_wait(inout int left, inout bit quiet);
        if (left == 0)
        begin
            left = $urandom_range(10, 60);
            quiet = ($urandom_range(0, 3) == 0);
        end
        left--;
        return quiet ? 0 : $urandom_range(0, 3);
    endfunction

    function automatic void queue_frame(input int unsigned dt, input logic hit,
                                        input coord_t ex, input coord_t ey, input coord_t ez,
                                        input coord_t hx, input coord_t hy, input coord_t hz);
        step_t s;
        sim_ms = sim_ms + time_t'(dt);
        s = '0;
        s.kind = STEP_WORD;
        s.req = REQ_FRAME;
        s.now = sim_ms;
        s.hit = hit;
        s.ex = ex;
        s.ey = ey;
        s.ez = ez;
        s.hx = hx;
        s.hy = hy;
        s.hz = hz;
        plan_q.push_back(s);
    endfunction

    function automatic void queue_reset(input int unsigned dt);
        step_t s;
        sim_ms = sim_ms + time_t'(dt);
        s = '0;
        s.kind = STEP_WORD;
        s.req = REQ_RESET;
        s.now = sim_ms;
        s.hit = 1'($urandom_range(0, 1));
        s.ex = coord_t'($urandom);
        s.hz = coord_t'($urandom);
        plan_q.push_back(s);
    endfunction

    function automatic void queue_cfg(input cfg_index_t idx, input cfg_data_t data);
        step_t s;
        s = '0;
        s.kind = STEP_CFG;
        s.idx = idx;
        s.data = data;
        plan_q.push_back(s);
    endfunction

    function automatic void queue_drain();
        step_t s;
        s = '0;
        s.kind = STEP_DRAIN;
        plan_q.push_back(s);
    endfunction

    function automatic coord_t sat_coord(input longint v);
        if (v > COORD_MAX)
            return coord_t'(COORD_MAX);
        if (v < COORD_MIN)
            return coord_t'(COORD_MIN);
        return coord_t'(v);
    endfunction

    // mostly tracked targets at a steady range, the rest resets, jumps and junk
    function automatic void queue_random(input int words);
        int     left;
        int     run;
        int     i;
        int     scale;
        longint ox;
        longint oy;
        longint oz;
        coord_t ex;
        coord_t ey;
        coord_t ez;
        int unsigned dt;
        left = words;
        while (left > 0)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                run = $urandom_range(4, 30);
                scale = (1 << $urandom_range(8, 21)) + $urandom_range(0, 255);
                ex = coord_t'($urandom);
                ey = coord_t'($urandom);
                ez = coord_t'($urandom);
                ox = longint'($urandom_range(0, 2 * scale)) - scale;
                oy = longint'($urandom_range(0, 2 * scale)) - scale;
                oz = longint'($urandom_range(0, 2 * scale)) - scale;
                for (i = 0; i < run && left > 0; i++)
                begin
                    ox += longint'($urandom_range(0, 64)) - 32;
                    oy += longint'($urandom_range(0, 64)) - 32;
                    oz += longint'($urandom_range(0, 64)) - 32;
                    dt = ($urandom_range(0, 9) == 0) ? $urandom_range(120, 1500)
                                                     : $urandom_range(0, 100);
                    queue_frame(dt, $urandom_range(0, 19) != 0, ex, ey, ez,
                                sat_coord(longint'(ex) + ox), sat_coord(longint'(ey) + oy),
                                sat_coord(longint'(ez) + oz));
                    left--;
                end
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0: queue_reset($urandom_range(0, 200));
                    1: queue_frame($urandom_range(0, 200), 1'($urandom_range(0, 1)),
                                   coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                                   coord_t'($urandom), coord_t'($urandom), coord_t'($urandom));
                    2:
                    begin
                        // jump anywhere in the 48-bit time space
                        sim_ms = time_t'({$urandom, $urandom});
                        queue_frame(0, 1'b1, coord_t'($urandom), coord_t'($urandom),
                                    coord_t'($urandom), coord_t'($urandom),
                                    coord_t'($urandom), coord_t'($urandom));
                    end
                    default: queue_frame($urandom_range(0, 150), 1'b0, '0, '0, '0,
                                         coord_t'($urandom_range(0, 100000)), '0, '0);
                endcase
                left--;
            end
        end
    endfunction

    // sender: one word in flight at a time, register writes only with nothing outstanding
    always @(posedge clk or negedge rst_n)
    begin
        logic  nxt_valid;
        logic  nxt_we;
        step_t head;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            cfg_we <= 1'b0;
        end
        else
        begin
            nxt_valid = in_valid;
            nxt_we = 1'b0;
            if (in_valid && in_ready)
            begin
                predict_aim(cur_word);
                words_sent++;
                nxt_valid = 1'b0;
                send_gap = draw_wait(send_left, send_quiet);
            end
            if (!nxt_valid)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (plan_q.size() > 0)
                begin
                    head = plan_q[0];
                    case (head.kind)
                        STEP_WORD:
                        begin
                            void'(plan_q.pop_front());
                            cur_word = head;
                            req_type <= head.req;
                            now_ms <= head.now;
                            hit_found <= head.hit;
                            eye_x <= head.ex;
                            eye_y <= head.ey;
                            eye_z <= head.ez;
                            hit_x <= head.hx;
                            hit_y <= head.hy;
                            hit_z <= head.hz;
                            nxt_valid = 1'b1;
                        end
                        STEP_CFG:
                        begin
                            if (expected_aims.size() == 0 && !in_valid)
                            begin
                                void'(plan_q.pop_front());
                                cfg_index <= head.idx;
                                cfg_data <= head.data;
                                nxt_we = 1'b1;
                                cfg_writes++;
                                case (head.idx)
                                    CFG_TRACING:  trc_en = head.data[0];
                                    CFG_MAX:      rng_max = head.data;
                                    CFG_MIN:      rng_min = head.data;
                                    CFG_INTERVAL: interval = head.data[INTERVAL_W-1:0];
                                    default:      ;
                                endcase
                            end
                        end
                        default:
                        begin
                            // hold off until every owed result is back
                            if (expected_aims.size() == 0)
                                void'(plan_q.pop_front());
                        end
                    endcase
                end
            end
            in_valid <= nxt_valid;
            cfg_we <= nxt_we;
        end
    end

    // receiver: compare each word with the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        aim_t want;
        logic nxt_ready;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (distance_valid === 1'b1)
                    valid_seen++;
                if (expected_aims.size() == 0)
                    report_mismatch($sformatf("unexpected word valid=%b dist=%0d",
                                              distance_valid, aim_distance));
                else
                begin
                    want = expected_aims.pop_front();
                    if (distance_valid !== want.present)
                        report_mismatch($sformatf("word %0d distance_valid %b, want %b",
                                                  results_seen, distance_valid, want.present));
                    if (aim_distance !== want.dist_q8)
                        report_mismatch($sformatf("word %0d aim_distance %0d, want %0d",
                                                  results_seen, aim_distance, want.dist_q8));
                end
                // long stall so the block backs up into its input
                if (results_seen == 400 || results_seen == 1300)
                    long_hold = 300;
                recv_gap = draw_wait(recv_left, recv_quiet);
            end
            if (long_hold > 0)
            begin
                long_hold--;
                nxt_ready = 1'b0;
            end
            else if (recv_gap > 0)
            begin
                recv_gap--;
                nxt_ready = 1'b0;
            end
            else
                nxt_ready = 1'b1;
            out_ready <= nxt_ready;
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, expected_aims.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        build_gain_table();

        // tracing still off after reset
        queue_frame(10, 1'b1, '0, '0, '0, 24'sd256000, '0, '0);
        queue_reset(5);
        queue_cfg(CFG_TRACING, 23'd1);

        // load, hold inside the interval, then measure right at the interval edge
        queue_frame(10, 1'b1, '0, '0, '0, 24'sd25600, '0, '0);
        queue_frame(10, 1'b1, '0, '0, '0, 24'sd51200, '0, '0);
        queue_frame(66, 1'b1, '0, '0, '0, 24'sd51200, '0, '0);
        queue_frame(66, 1'b1, '0, '0, '0, '0, 24'sd30000, '0);
        queue_frame(65, 1'b1, '0, '0, '0, '0, 24'sd90000, '0);
        queue_frame(1, 1'b0, '0, '0, '0, '0, 24'sd30000, '0);

        // window edges
        queue_frame(1, 1'b1, '0, '0, '0, 24'sd2048, '0, '0);
        queue_frame(1, 1'b1, '0, '0, '0, 24'sd2049, '0, '0);
        queue_reset(1);
        queue_frame(1, 1'b1, '0, '0, '0, 24'sd2015744, '0, '0);
        queue_frame(1, 1'b1, '0, '0, '0, 24'sd2015743, '0, '0);

        // long gaps around the end of the gain table
        queue_frame(5000, 1'b1, 24'sd100, -24'sd200, 24'sd300, -24'sd1000, 24'sd1500, -24'sd7000);
        queue_frame(1022, 1'b1, '0, '0, '0, '0, '0, 24'sd500000);
        queue_frame(1023, 1'b1, '0, '0, '0, '0, '0, 24'sd1000000);

        // corner points of the coordinate space, then zero distance
        queue_frame(100, 1'b1, coord_t'(COORD_MIN), coord_t'(COORD_MIN), coord_t'(COORD_MIN),
                    coord_t'(COORD_MAX), coord_t'(COORD_MAX), coord_t'(COORD_MAX));
        queue_frame(100, 1'b1, coord_t'(COORD_MAX), coord_t'(COORD_MAX), coord_t'(COORD_MAX),
                    coord_t'(COORD_MIN), coord_t'(COORD_MIN), coord_t'(COORD_MIN));
        queue_frame(100, 1'b1, 24'sd5, 24'sd5, 24'sd5, 24'sd5, 24'sd5, 24'sd5);

        // timestamp wraps past 2^48
        sim_ms = 48'hFFFF_FFFF_FFFB;
        queue_frame(0, 1'b1, 24'sd1000, 24'sd1000, 24'sd1000, 24'sd5000, -24'sd3000, 24'sd2000);
        queue_frame(8, 1'b1, 24'sd1000, 24'sd1000, 24'sd1000, 24'sd9000, 24'sd1000, 24'sd1000);
        queue_frame(100, 1'b1, 24'sd1000, 24'sd1000, 24'sd1000, 24'sd9000, 24'sd1000, 24'sd1000);

        queue_random(150);
        queue_drain();
        queue_random(150);

        queue_cfg(CFG_INTERVAL, 23'd0);
        queue_cfg(CFG_MIN, 23'd0);
        queue_cfg(CFG_MAX, 23'd8388607);
        queue_random(300);

        queue_cfg(CFG_INTERVAL, 23'd65535);
        queue_cfg(CFG_MIN, MIN_RANGE_RST);
        queue_cfg(CFG_MAX, MAX_RANGE_RST);
        queue_random(250);

        // empty window: nothing can pass
        queue_cfg(CFG_MIN, 23'd8388607);
        queue_cfg(CFG_MAX, 23'd0);
        queue_cfg(CFG_INTERVAL, 23'd10);
        queue_random(100);
        queue_cfg(CFG_MIN, 23'd300000);
        queue_cfg(CFG_MAX, 23'd300000);
        queue_random(80);

        queue_cfg(CFG_TRACING, 23'd0);
        queue_random(100);
        queue_cfg(CFG_TRACING, 23'd1);

        repeat (2)
        begin
            queue_cfg(CFG_MAX, cfg_data_t'($urandom_range(500000, 8388607)));
            queue_cfg(CFG_MIN, cfg_data_t'($urandom_range(0, 20000)));
            queue_cfg(CFG_INTERVAL, cfg_data_t'($urandom_range(0, 150)));
            queue_random(300);
        end

        queue_cfg(CFG_MIN, MIN_RANGE_RST);
        queue_cfg(CFG_MAX, MAX_RANGE_RST);
        queue_cfg(CFG_INTERVAL, cfg_data_t'(INTERVAL_RST));
        queue_random(250);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (plan_q.size() != 0 || in_valid || expected_aims.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d words under %0d register writes; %0d results, %0d with a distance",
                 words_sent, cfg_writes, results_seen, valid_seen);
        $display("Covered window edges, wrapped time, saturated gaps and back-pressure stalls");
        if (err_count == 0 && expected_aims.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

/* rate_limited_range_smoother.f */
rtl/core/rlrs_pkg.sv
rtl/core/rlrs_blend_rom.sv
rtl/core/rlrs_isqrt.sv
rtl/core/rate_limited_range_smoother.sv
bench/testbench.sv
